[rtl/core/bsfe_pkg.sv]
// ----------------------------------------------------------------------------
// bsfe_pkg: shared types and constants for the bookmark set block
// Status codes, payload types, and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfe_pkg;

	// Default sizing of the store
	localparam int MAX_BOOKS_DEF = 256;
	localparam int MAX_MARKS_DEF = 8;

	// Payload field types (fixed by the channel definition)
	typedef logic [0:0]  op_t;
	typedef logic [7:0]  index_t;
	typedef logic [31:0] line_t;
	typedef logic [2:0]  status_t;
	typedef logic [3:0]  count_t;
	typedef logic [8:0]  book_count_t;

	// Operation codes
	localparam op_t OP_ADD    = 1'b0;
	localparam op_t OP_REMOVE = 1'b1;

	// Result status codes
	localparam status_t ST_ADDED    = 3'd0;
	localparam status_t ST_PRESENT  = 3'd1;
	localparam status_t ST_EVICTED  = 3'd2;
	localparam status_t ST_REMOVED  = 3'd3;
	localparam status_t ST_ABSENT   = 3'd4;
	localparam status_t ST_BADINDEX = 3'd5;

	// Register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_BOOK_COUNT = 1'b0;   // word select paddr[2]

	// Controller -> datapath commands
	typedef struct packed {
		logic    load_item;   // capture request, check index
		logic    rd_cnt;      // read count store
		logic    load_cnt;    // latch count, clear walk pointers
		logic    rd_line;     // issue line read at walk pointer, advance
		logic    shift;       // returned data moves down one slot
		logic    ptr_one;     // start shift walk at slot one
		logic    wr_new;      // write request line at tail
		logic    wr_cnt;      // write new count back
		logic    res_load;    // load output register
		status_t res_code;
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic bad;         // record index rejected
		logic op_rm;       // request is a remove
		logic more_scan;   // walk pointer below count
		logic more_shift;  // walk pointer below list size
		logic hit;         // line matched at least once
		logic full;        // list holds its maximum
		logic out_free;    // output register can take a result
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/bsfe_ifs.sv]
// ----------------------------------------------------------------------------
// bsfe_ifs: request and response channels of the bookmark set block
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsfe_req_if;
	logic                valid;
	logic                ready;
	bsfe_pkg::op_t       operation;
	bsfe_pkg::index_t    book_index;
	bsfe_pkg::line_t     line_number;

	modport source(output valid, operation, book_index, line_number, input ready);
	modport sink(input valid, operation, book_index, line_number, output ready);
endinterface

interface bsfe_rsp_if;
	logic                valid;
	logic                ready;
	bsfe_pkg::status_t   status;
	bsfe_pkg::count_t    count_after;
	bsfe_pkg::line_t     evicted_line;

	modport source(output valid, status, count_after, evicted_line, input ready);
	modport sink(input valid, status, count_after, evicted_line, output ready);
endinterface

`default_nettype wire

[rtl/core/bookmark_set_fifo_evict.sv]
// ----------------------------------------------------------------------------
// bookmark_set_fifo_evict: bounded bookmark sets with oldest-first eviction
// Per-record ordered lists of line numbers; add with duplicate check and
// eviction, remove with in-order compaction, configurable record count.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake        Payload
//  -------   ---   --------------   ------------------------------------------
//  req       in    valid/ready      operation, book_index, line_number
//  rsp       out   valid/ready      status, count_after, evicted_line
//  apb       in    psel/penable     book_count at byte address 0
//
//  A request reads each entry of its record in turn before its result is
//  loaded; a rejected index skips the walk, and an add that evicts walks again.
//  The walk reads the line store one entry per cycle through its single read
//  port; the eviction adds a second walk that moves each entry down a slot.
//  Reset clears the record count and the per-record count valid bits at once;
//  no clearing pass runs, since a line slot is only read below its count.
//  A held result in the output register does not block the next request.
//
`default_nettype none

module bookmark_set_fifo_evict #(
	parameter int MAX_BOOKS = bsfe_pkg::MAX_BOOKS_DEF,
	parameter int MAX_MARKS = bsfe_pkg::MAX_MARKS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	bsfe_req_if.sink                           req,
	bsfe_rsp_if.source                         rsp,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire [bsfe_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire [bsfe_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bsfe_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	bsfe_pkg::book_count_t book_count_q;
	bsfe_pkg::cmd_t        cmd;
	bsfe_pkg::sts_t        sts;
	logic                  cfg_wr;

	// Configuration register: write on the access phase, word select paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			book_count_q <= '0;
		end else if (cfg_wr && paddr[2] == bsfe_pkg::REG_BOOK_COUNT) begin
			book_count_q <= pwdata[$bits(bsfe_pkg::book_count_t)-1:0];
		end
	end

	// Readback: unmapped word reads as zero
	assign prdata = (paddr[2] == bsfe_pkg::REG_BOOK_COUNT) ?
		bsfe_pkg::APB_DATA_W'(book_count_q) : '0;

	// Sequencer: one request at a time
	bsfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stores, walk logic and output register
	bsfe_dpath #(
		.MAX_BOOKS (MAX_BOOKS),
		.MAX_MARKS (MAX_MARKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (req.operation),
		.book_index   (req.book_index),
		.line_number  (req.line_number),
		.book_count   (book_count_q),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.status       (rsp.status),
		.count_after  (rsp.count_after),
		.evicted_line (rsp.evicted_line)
	);

endmodule

`default_nettype wire

[rtl/core/bsfe_dpath.sv]
// ----------------------------------------------------------------------------
// bsfe_dpath: datapath of the bookmark set block
// Count store with valid bits, line store, walk pointers, compare and
// compaction logic, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_dpath #(
	parameter int MAX_BOOKS = bsfe_pkg::MAX_BOOKS_DEF,
	parameter int MAX_MARKS = bsfe_pkg::MAX_MARKS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  bsfe_pkg::cmd_t            cmd,
	output bsfe_pkg::sts_t            sts,
	input  bsfe_pkg::op_t             operation,
	input  bsfe_pkg::index_t          book_index,
	input  bsfe_pkg::line_t           line_number,
	input  bsfe_pkg::book_count_t     book_count,
	output logic                      out_valid,
	input  wire                       out_ready,
	output bsfe_pkg::status_t         status,
	output bsfe_pkg::count_t          count_after,
	output bsfe_pkg::line_t           evicted_line
);

	// Records beyond the index range can never be addressed
	localparam int BOOKS  = (MAX_BOOKS < 256) ? MAX_BOOKS : 256;
	localparam int CAW    = (BOOKS > 1) ? $clog2(BOOKS) : 1;
	localparam int CW     = $clog2(MAX_MARKS + 1);
	localparam int LDEPTH = BOOKS * MAX_MARKS;
	localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
	localparam bsfe_pkg::book_count_t BOOKS_W = bsfe_pkg::book_count_t'(BOOKS);

	// Request
	bsfe_pkg::op_t    op_q;
	bsfe_pkg::index_t idx_q;
	bsfe_pkg::line_t  line_q;
	logic             bad_q;

	// Count store
	logic [CW-1:0]    cmem [BOOKS];
	logic [BOOKS-1:0] cvld_q;
	logic [CW-1:0]    cnt_rd_q;
	logic             cvld_rd_q;
	logic [CAW-1:0]   caddr;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_new;

	// Line store and walk
	bsfe_pkg::line_t  lmem [LDEPTH];
	bsfe_pkg::line_t  rdata_q;
	logic             rvld_q;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    dptr_q;
	logic [CW-1:0]    kept_q;
	logic             hit_q;
	bsfe_pkg::line_t  evict_q;
	logic [LAW-1:0]   base_q;
	logic [LAW-1:0]   rd_addr;
	logic             lwr_en;
	logic [LAW-1:0]   lwr_addr;
	bsfe_pkg::line_t  lwr_data;
	logic             match;
	logic             full;

	// Output register
	logic               out_vld_q;
	bsfe_pkg::status_t  status_q;
	bsfe_pkg::count_t   count_q;
	bsfe_pkg::line_t    evicted_q;
	logic [CW-1:0]      res_cnt;

	assign caddr   = idx_q[CAW-1:0];
	assign full    = (cnt_q == CW'(MAX_MARKS));
	assign match   = (rdata_q == line_q);
	assign cnt_new = (op_q == bsfe_pkg::OP_REMOVE) ? kept_q : cnt_q + CW'(1);
	assign rd_addr = base_q + LAW'(ptr_q);

	// Request capture and index check
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= operation;
			idx_q  <= book_index;
			line_q <= line_number;
			bad_q  <= ({1'b0, book_index} >= book_count) || ({1'b0, book_index} >= BOOKS_W);
		end
	end

	// Count store: payload in a memory, valid bits cleared by reset
	always_ff @(posedge clk) begin
		if (cmd.wr_cnt) begin
			cmem[caddr] <= cnt_new;
		end
		if (cmd.rd_cnt) begin
			cnt_rd_q <= cmem[caddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q    <= '0;
			cvld_rd_q <= 1'b0;
		end else begin
			if (cmd.wr_cnt) begin
				cvld_q[caddr] <= 1'b1;
			end
			if (cmd.rd_cnt) begin
				cvld_rd_q <= cvld_q[caddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cnt) begin
			cnt_q  <= cvld_rd_q ? cnt_rd_q : '0;
			base_q <= LAW'(idx_q) * LAW'(MAX_MARKS);
		end
	end

	// Walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			dptr_q <= '0;
			rvld_q <= 1'b0;
			kept_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			rvld_q <= cmd.rd_line;
			if (cmd.rd_line) begin
				dptr_q <= ptr_q;
			end
			if (cmd.load_cnt) begin
				ptr_q  <= '0;
				kept_q <= '0;
				hit_q  <= 1'b0;
			end else if (cmd.ptr_one) begin
				ptr_q <= CW'(1);
			end else if (cmd.rd_line) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (rvld_q && !cmd.shift) begin
				if (match) begin
					hit_q <= 1'b1;
				end else if (op_q == bsfe_pkg::OP_REMOVE) begin
					kept_q <= kept_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_q && !cmd.shift && dptr_q == '0) begin
			evict_q <= rdata_q;
		end
	end

	// Line store write: compaction, shift down, or new tail entry
	always_comb begin
		lwr_en   = 1'b0;
		lwr_addr = base_q + LAW'(kept_q);
		lwr_data = rdata_q;
		priority if (rvld_q && cmd.shift) begin
			lwr_en   = 1'b1;
			lwr_addr = base_q + LAW'(dptr_q) - LAW'(1);
		end else if (rvld_q && !match && op_q == bsfe_pkg::OP_REMOVE) begin
			lwr_en = 1'b1;
		end else if (cmd.wr_new) begin
			lwr_en   = 1'b1;
			lwr_addr = base_q + (full ? LAW'(MAX_MARKS - 1) : LAW'(cnt_q));
			lwr_data = line_q;
		end else begin
			lwr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lwr_en) begin
			lmem[lwr_addr] <= lwr_data;
		end
		if (cmd.rd_line) begin
			rdata_q <= lmem[rd_addr];
		end
	end

	// Result selection and output register
	always_comb begin
		unique case (cmd.res_code)
			bsfe_pkg::ST_BADINDEX: res_cnt = '0;
			bsfe_pkg::ST_ADDED:    res_cnt = cnt_q + CW'(1);
			bsfe_pkg::ST_REMOVED:  res_cnt = kept_q;
			default:               res_cnt = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q  <= cmd.res_code;
			count_q   <= bsfe_pkg::count_t'(res_cnt);
			evicted_q <= (cmd.res_code == bsfe_pkg::ST_EVICTED) ? evict_q : '0;
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign count_after  = count_q;
	assign evicted_line = evicted_q;

	assign sts.bad        = bad_q;
	assign sts.op_rm      = (op_q == bsfe_pkg::OP_REMOVE);
	assign sts.more_scan  = (ptr_q < cnt_q);
	assign sts.more_shift = (ptr_q < CW'(MAX_MARKS));
	assign sts.hit        = hit_q;
	assign sts.full       = full;
	assign sts.out_free   = !out_vld_q || out_ready;

endmodule

`default_nettype wire

[rtl/core/bsfe_ctrl.sv]
// ----------------------------------------------------------------------------
// bsfe_ctrl: sequencer of the bookmark set block
// Steps one request through index check, count read, list walk, write-back
// and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  bsfe_pkg::sts_t   sts,
	output bsfe_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHK    = 3'd1;
	localparam logic [2:0] S_CNT    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_SHIFT  = 3'd5;
	localparam logic [2:0] S_LAST   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	bsfe_pkg::status_t code_q;
	bsfe_pkg::status_t code_d;

	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.res_code = code_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.bad) begin
					code_d  = bsfe_pkg::ST_BADINDEX;
					state_d = S_DONE;
				end else begin
					cmd.rd_cnt = 1'b1;
					state_d    = S_CNT;
				end
			end
			S_CNT: begin
				cmd.load_cnt = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				if (sts.more_scan) begin
					cmd.rd_line = 1'b1;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (sts.op_rm) begin
					if (sts.hit) begin
						cmd.wr_cnt = 1'b1;
						code_d     = bsfe_pkg::ST_REMOVED;
					end else begin
						code_d = bsfe_pkg::ST_ABSENT;
					end
				end else if (sts.hit) begin
					code_d = bsfe_pkg::ST_PRESENT;
				end else if (!sts.full) begin
					cmd.wr_new = 1'b1;
					cmd.wr_cnt = 1'b1;
					code_d     = bsfe_pkg::ST_ADDED;
				end else begin
					cmd.ptr_one = 1'b1;
					state_d     = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.more_shift) begin
					cmd.rd_line = 1'b1;
				end else begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				cmd.wr_new = 1'b1;
				code_d     = bsfe_pkg::ST_EVICTED;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= bsfe_pkg::ST_ADDED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

`default_nettype wire

[tb/tb_bookmark_set_fifo_evict.sv]
// ----------------------------------------------------------------------------
// tb_bookmark_set_fifo_evict: self-checking bench for the bookmark set block
// Drives add and remove requests through the request channel and mirrors
// every record's list and count in a class. Each accepted request is
// predicted at once. Each accepted response is compared field by field with
// the oldest prediction. The record count register is stepped through
// several values over APB, with the block idle at every write.
// ----------------------------------------------------------------------------

module tb_bookmark_set_fifo_evict;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOOKS       = bsfe_pkg::MAX_BOOKS_DEF;
	localparam int MARKS       = bsfe_pkg::MAX_MARKS_DEF;
	localparam int CYCLE_LIMIT = 400000;  // watchdog bound that ends a hung run
	localparam int SETTLE      = 30;      // outlasts the longest request (eviction)
	localparam int IDLE_PCT    = 11;
	localparam int POOL_SIZE   = 12;      // more lines than slots forces eviction
	localparam int PHASE_ITEMS = 290;
	localparam int SHOWN_MAX   = 10;

	// Word select of the unused second register slot
	localparam logic REG_SPARE = 1'b1;

	typedef struct packed {
		bsfe_pkg::status_t status;
		bsfe_pkg::count_t  count_after;
		bsfe_pkg::line_t   evicted_line;
	} outcome_t;

	// Mirror of the bookmark store. It holds the lists, the counts, the record
	// count and the queue of outcomes still owed by the block.
	class bookmark_mirror;
		bsfe_pkg::line_t       marks [BOOKS][MARKS];
		bsfe_pkg::count_t      fill [BOOKS];
		bsfe_pkg::book_count_t books;
		outcome_t              owed_q [$];
		int                    mismatches;

		function new();
			foreach (marks[b, m]) marks[b][m] = '0;
			foreach (fill[b]) fill[b] = '0;
			books = '0;
			mismatches = 0;
		endfunction

		function void set_books(bsfe_pkg::book_count_t value);
			books = value;
		endfunction

		function int waiting();
			return owed_q.size();
		endfunction

		// Apply one accepted request to the lists and queue its outcome.
		function void apply_request(bsfe_pkg::op_t op, bsfe_pkg::index_t idx,
			bsfe_pkg::line_t line);
			outcome_t o;
			int       n;
			int       kept;
			bit       found;

			o = '0;
			if ({1'b0, idx} >= books) begin
				o.status = bsfe_pkg::ST_BADINDEX;
				owed_q.push_back(o);
				return;
			end
			n = int'(fill[idx]);
			if (op == bsfe_pkg::OP_ADD) begin
				found = 1'b0;
				for (int i = 0; i < n; i++)
					if (marks[idx][i] == line) found = 1'b1;
				if (found) begin
					o.status = bsfe_pkg::ST_PRESENT;
					o.count_after = bsfe_pkg::count_t'(n);
				end else if (n < MARKS) begin
					marks[idx][n] = line;
					fill[idx] = bsfe_pkg::count_t'(n + 1);
					o.status = bsfe_pkg::ST_ADDED;
					o.count_after = bsfe_pkg::count_t'(n + 1);
				end else begin
					o.status = bsfe_pkg::ST_EVICTED;
					o.count_after = bsfe_pkg::count_t'(n);
					o.evicted_line = marks[idx][0];
					for (int i = 0; i + 1 < MARKS; i++)
						marks[idx][i] = marks[idx][i + 1];
					marks[idx][MARKS - 1] = line;
				end
			end else begin
				kept = 0;
				for (int i = 0; i < n; i++) begin
					if (marks[idx][i] != line) begin
						marks[idx][kept] = marks[idx][i];
						kept++;
					end
				end
				if (kept == n) begin
					o.status = bsfe_pkg::ST_ABSENT;
					o.count_after = bsfe_pkg::count_t'(n);
				end else begin
					for (int i = kept; i < MARKS; i++) marks[idx][i] = '0;
					fill[idx] = bsfe_pkg::count_t'(kept);
					o.status = bsfe_pkg::ST_REMOVED;
					o.count_after = bsfe_pkg::count_t'(kept);
				end
			end
			owed_q.push_back(o);
		endfunction

		// Compare one accepted response with the oldest owed outcome.
		function void compare_outcome(bsfe_pkg::status_t st, bsfe_pkg::count_t cnt,
			bsfe_pkg::line_t ev);
			outcome_t o;

			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("[%0t] response with none owed: status %0d count %0d evicted %h",
						$realtime, st, cnt, ev);
				return;
			end
			o = owed_q.pop_front();
			if (o.status != st || o.count_after != cnt || o.evicted_line != ev) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("[%0t] mismatch: expected status %0d count %0d evicted %h, %s %0d %0d %h",
						$realtime, o.status, o.count_after, o.evicted_line,
						"got", st, cnt, ev);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [bsfe_pkg::APB_ADDR_W-1:0] paddr;
	logic [bsfe_pkg::APB_DATA_W-1:0] pwdata;
	logic [bsfe_pkg::APB_DATA_W-1:0] prdata;
	logic        pready;

	bit          calm;     // when set, neither side idles
	int unsigned cycles;
	bookmark_mirror mirror;

	bsfe_req_if req_ch ();
	bsfe_rsp_if rsp_ch ();

	bookmark_set_fifo_evict dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_bookmark_set_fifo_evict failed");
			$finish;
		end
	end

	// Receiver: stall the response channel now and then, never while calm
	always @(negedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Observe both channels at the rising edge. A request transaction updates
	// the mirror; a response transaction is checked against it.
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			mirror.apply_request(req_ch.operation, req_ch.book_index, req_ch.line_number);
		if (rsp_ch.valid && rsp_ch.ready)
			mirror.compare_outcome(rsp_ch.status, rsp_ch.count_after, rsp_ch.evicted_line);
	end

	// Present one request and hold it until the block takes it. Random idle
	// cycles come only before valid rises, never while a request waits.
	task automatic send_request(input bsfe_pkg::op_t op, input bsfe_pkg::index_t idx,
		input bsfe_pkg::line_t line);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.book_index  <= idx;
		req_ch.line_number <= line;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Drop valid, wait for every owed response, then let the block go quiet.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (mirror.waiting() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic sel, input logic [bsfe_pkg::APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == bsfe_pkg::REG_BOOK_COUNT) mirror.set_books(data[8:0]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// One random phase at a given record count. Most requests are adds and
	// removes drawn from a small pool of lines on a few records, so lists
	// fill, hit duplicates and evict; the rest are noise over all fields.
	task automatic run_phase(input bsfe_pkg::book_count_t books, input bit calm_start,
		input bit pause_mid);
		bsfe_pkg::line_t  pool [POOL_SIZE];
		bsfe_pkg::op_t    op;
		bsfe_pkg::index_t idx;
		bsfe_pkg::line_t  line;
		int               pick;

		drain();
		// Set random upper bits; only the low nine bits hold the count
		write_reg(bsfe_pkg::REG_BOOK_COUNT, ($urandom() & 32'hFFFF_FE00) | 32'(books));
		foreach (pool[k]) pool[k] = $urandom();
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			calm = calm_start && (n < PHASE_ITEMS / 2);
			// Hold off until the block has answered everything
			if (pause_mid && n == PHASE_ITEMS / 2) drain();
			pick = $urandom_range(99);
			if (pick < 8) begin
				op   = bsfe_pkg::op_t'($urandom_range(1));
				idx  = bsfe_pkg::index_t'($urandom_range(BOOKS - 1));
				line = $urandom();
			end else begin
				op   = ($urandom_range(99) < 65) ? bsfe_pkg::OP_ADD : bsfe_pkg::OP_REMOVE;
				line = pool[$urandom_range(POOL_SIZE - 1)];
				if (int'(books) < BOOKS && pick < 14)
					idx = bsfe_pkg::index_t'($urandom_range(BOOKS - 1, int'(books)));
				else if (int'(books) > 16 && pick < 75)
					idx = bsfe_pkg::index_t'($urandom_range(7));
				else
					idx = bsfe_pkg::index_t'($urandom_range(int'(books) - 1));
			end
			send_request(op, idx, line);
		end
		calm = 1'b0;
	endtask

	initial begin
		mirror = new();
		cycles = 0;
		calm   = 1'b0;
		arst_n = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		req_ch.valid       = 1'b0;
		req_ch.operation   = bsfe_pkg::OP_ADD;
		req_ch.book_index  = '0;
		req_ch.line_number = '0;
		rsp_ch.ready       = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Record count resets to zero: reject everything
		send_request(bsfe_pkg::OP_ADD, 8'd0, 32'd5);
		send_request(bsfe_pkg::OP_REMOVE, 8'd255, 32'd0);
		// A write to the unused slot must not open any record
		drain();
		write_reg(REG_SPARE, 32'h0000_01FF);
		send_request(bsfe_pkg::OP_ADD, 8'd0, 32'd0);

		// Full range of records; upper data bits are dropped
		drain();
		write_reg(bsfe_pkg::REG_BOOK_COUNT, 32'hABCD_E100);
		send_request(bsfe_pkg::OP_ADD, 8'd255, 32'hFFFF_FFFF);
		send_request(bsfe_pkg::OP_ADD, 8'd255, 32'd0);
		send_request(bsfe_pkg::OP_ADD, 8'd255, 32'hFFFF_FFFF);     // duplicate add
		send_request(bsfe_pkg::OP_REMOVE, 8'd255, 32'h1234_5678);  // remove of an absent line
		send_request(bsfe_pkg::OP_REMOVE, 8'd255, 32'hFFFF_FFFF);
		send_request(bsfe_pkg::OP_REMOVE, 8'd0, 32'd0);            // remove from an empty list
		send_request(bsfe_pkg::OP_ADD, 8'd0, 32'd0);
		// Fill one record, then evict the oldest twice
		for (int k = 0; k < MARKS; k++)
			send_request(bsfe_pkg::OP_ADD, 8'd7, bsfe_pkg::line_t'(100 + k));
		send_request(bsfe_pkg::OP_ADD, 8'd7, 32'd108);
		send_request(bsfe_pkg::OP_ADD, 8'd7, 32'd103);
		send_request(bsfe_pkg::OP_REMOVE, 8'd7, 32'd104);
		send_request(bsfe_pkg::OP_ADD, 8'd7, 32'd109);
		send_request(bsfe_pkg::OP_ADD, 8'd7, 32'd110);
		send_request(bsfe_pkg::OP_REMOVE, 8'd7, 32'd110);          // remove of the newest entry

		// Random phases across the register's range; the third starts with a
		// stretch of no idling, the second pauses for a full drain midway
		run_phase(9'd1, 1'b0, 1'b0);
		run_phase(9'd255, 1'b0, 1'b1);
		run_phase(9'd16, 1'b1, 1'b0);
		run_phase(bsfe_pkg::book_count_t'($urandom_range(254, 2)), 1'b0, 1'b0);
		run_phase(9'd256, 1'b0, 1'b0);

		drain();
		if (mirror.mismatches == 0 && mirror.waiting() == 0) begin
			$display("tb_bookmark_set_fifo_evict passed");
		end else begin
			$display("tb_bookmark_set_fifo_evict failed");
		end
		$finish;
	end

endmodule
